// ----- hw/rtl/pgu_pkg.sv -----
// Package of shared types and constants for the pheromone grid update unit.
`timescale 1ns / 1ps
package pgu_pkg;

  // Storage geometry (powers of two, one RAM word per cell).
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int GRID_DEPTH  = 1 << ADDR_W;

  // Field and register widths.
  localparam int LEVEL_W = 7;
  localparam int CFG_W   = 7;

  // Level arithmetic.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
  localparam logic [LEVEL_W-1:0] DEPOSIT_STEP = 7'd5;
  localparam logic [LEVEL_W-1:0] EVAP_STEP    = 7'd1;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_EVAPORATE = 2'd0,
    ACT_DEPOSIT   = 2'd1,
    ACT_READ      = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAP,
    ST_DEPOSIT,
    ST_READ,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] column;
    logic [5:0] row;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] cell_level;
    logic               out_of_bounds;
  } result_t;

endpackage

// ----- hw/rtl/pgu_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module pgu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pheromone_grid_update_unit.sv -----
// Top level of the pheromone grid update unit: sequencer, level update unit and grid RAM.
`timescale 1ns / 1ps
// The unit keeps a grid of pheromone levels (0 to 100) in one RAM word per cell.
// A command word on cmd_i is taken at a rising edge where start is high and busy
// is low. Evaporate lowers every active cell by one, deposit adds five to the
// in-bounds 3x3 neighbourhood (ten at the centre) with saturation at 100, and
// read returns one cell. Every command gives exactly one result word on result_o,
// shown for one cycle with done_o high; the receiver cannot hold it off.
// Evaporate visits every active cell, one cell per cycle; deposit visits the nine
// neighbour slots, one per cycle, and writes the in-bounds ones; read fetches one
// cell; an unused action, or a deposit or read outside the grid, only gives the
// result word, flagged out of bounds for the latter two.
// The rate is set by the single read/write RAM pair: the shared update unit reads
// one cell per cycle and writes the updated level back in the next cycle, so reads
// and writes overlap on different cells. Busy is high during the whole command.
// After reset the unit sweeps all 4096 cells to zero, one per cycle, keeping busy high
// during the sweep; configuration writes are taken meanwhile. Grid width and height are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle, a rule on the user that
// the block does not enforce; values above 64 act as 64, and zero gives an empty grid.
module pheromone_grid_update_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pgu_pkg::cmd_t                cmd_i,
  output logic                         done_o,
  output pgu_pkg::result_t             result_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pgu_pkg::CFG_W-1:0]    cfg_wdata_i
);

  import pgu_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] grid_width_q, grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_W'(MAX_COLUMNS);
      grid_height_q <= CFG_W'(MAX_ROWS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default:         grid_width_q  <= grid_width_q;
      endcase
    end
  end

  // Active grid size, clipped to the storage.
  logic [COL_W:0] w_eff;
  logic [ROW_W:0] h_eff;

  assign w_eff = (int'(grid_width_q) > MAX_COLUMNS) ? (COL_W+1)'(MAX_COLUMNS)
                                                   : (COL_W+1)'(grid_width_q);
  assign h_eff = (int'(grid_height_q) > MAX_ROWS) ? (ROW_W+1)'(MAX_ROWS)
                                                 : (ROW_W+1)'(grid_height_q);

  // Sequencer state.
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       dc_q, dc_d;
  logic [1:0]       dr_q, dr_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;
  logic             oob_q, oob_d;

  // Payload registers.
  cmd_t              cmd_q, cmd_d;
  logic [ADDR_W-1:0] wb_addr_q, wb_addr_d;
  logic              wb_centre_q, wb_centre_d;
  result_t           result_q, result_d;

  // RAM ports.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [LEVEL_W-1:0] ram_wdata, ram_rdata;

  pgu_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared level update unit: an add or a subtract and a compare on the word just read.
  logic [LEVEL_W:0]   upd_sum;
  logic [LEVEL_W-1:0] upd_level;

  always_comb begin
    upd_sum = {1'b0, ram_rdata} + {1'b0, (wb_centre_q ? (DEPOSIT_STEP + DEPOSIT_STEP)
                                                      : DEPOSIT_STEP)};
    if (action_e'(cmd_q.action) == ACT_EVAPORATE) begin
      upd_level = (ram_rdata < EVAP_STEP) ? '0 : ram_rdata - EVAP_STEP;
    end else begin
      upd_level = (upd_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : upd_sum[LEVEL_W-1:0];
    end
  end

  // Position checks for the command being started and for deposit neighbours.
  logic accept;
  logic start_inside;
  logic nb_col_ok, nb_row_ok;
  logic [COL_W-1:0] nb_col;
  logic [ROW_W-1:0] nb_row;
  logic last_row, last_col;

  assign accept       = start && !busy;
  assign start_inside = (int'(cmd_i.column) < int'(w_eff)) &&
                        (int'(cmd_i.row) < int'(h_eff));

  always_comb begin
    unique case (dc_q)
      2'd0:    nb_col_ok = (cmd_q.column != '0);
      2'd1:    nb_col_ok = 1'b1;
      default: nb_col_ok = (int'(cmd_q.column) + 1) < int'(w_eff);
    endcase
    unique case (dr_q)
      2'd0:    nb_row_ok = (cmd_q.row != '0);
      2'd1:    nb_row_ok = 1'b1;
      default: nb_row_ok = (int'(cmd_q.row) + 1) < int'(h_eff);
    endcase
  end

  assign nb_col   = COL_W'(int'(cmd_q.column) + int'(dc_q) - 1);
  assign nb_row   = ROW_W'(int'(cmd_q.row) + int'(dr_q) - 1);
  assign last_row = ({1'b0, row_q} == (h_eff - 1'b1));
  assign last_col = ({1'b0, col_q} == (w_eff - 1'b1));

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    dc_d        = dc_q;
    dr_d        = dr_q;
    pend_d      = 1'b0;
    done_d      = 1'b0;
    oob_d       = oob_q;
    cmd_d       = cmd_q;
    wb_addr_d   = wb_addr_q;
    wb_centre_d = 1'b0;
    result_d    = result_q;
    ram_raddr   = {col_q, row_q};

    // The write-back stage finishes the cell read in the previous cycle.
    ram_we    = pend_q && (action_e'(cmd_q.action) != ACT_READ);
    ram_waddr = wb_addr_q;
    ram_wdata = upd_level;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {col_q, row_q};
        ram_wdata = '0;
        {col_d, row_d} = {col_q, row_q} + 1'b1;
        if ({col_q, row_q} == {ADDR_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          col_d = '0;
          row_d = '0;
          dc_d  = '0;
          dr_d  = '0;
          oob_d = 1'b0;
          case (action_e'(cmd_i.action))
            ACT_EVAPORATE: begin
              state_d = (w_eff == '0 || h_eff == '0) ? ST_DRAIN : ST_EVAP;
            end
            ACT_DEPOSIT: begin
              oob_d   = !start_inside;
              state_d = start_inside ? ST_DEPOSIT : ST_DRAIN;
            end
            ACT_READ: begin
              oob_d   = !start_inside;
              state_d = start_inside ? ST_READ : ST_DRAIN;
            end
            default: state_d = ST_DRAIN;
          endcase
        end
      end

      ST_EVAP: begin
        pend_d    = 1'b1;
        wb_addr_d = {col_q, row_q};
        if (last_row) begin
          row_d = '0;
          col_d = col_q + 1'b1;
          if (last_col) begin
            state_d = ST_DRAIN;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      ST_DEPOSIT: begin
        ram_raddr   = {nb_col, nb_row};
        pend_d      = nb_col_ok && nb_row_ok;
        wb_addr_d   = {nb_col, nb_row};
        wb_centre_d = (dc_q == 2'd1) && (dr_q == 2'd1);
        if (dr_q == 2'd2) begin
          dr_d = '0;
          dc_d = dc_q + 1'b1;
          if (dc_q == 2'd2) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dr_d = dr_q + 1'b1;
        end
      end

      ST_READ: begin
        ram_raddr = {COL_W'(cmd_q.column), ROW_W'(cmd_q.row)};
        pend_d    = 1'b1;
        state_d   = ST_DRAIN;
      end

      ST_DRAIN: begin
        done_d                 = 1'b1;
        result_d.out_of_bounds = oob_q;
        result_d.cell_level    = (pend_q && action_e'(cmd_q.action) == ACT_READ)
                                 ? ram_rdata : '0;
        state_d                = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      dc_q    <= '0;
      dr_q    <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      oob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      dc_q    <= dc_d;
      dr_q    <= dr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      oob_q   <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    wb_addr_q   <= wb_addr_d;
    wb_centre_q <= wb_centre_d;
    result_q    <= result_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // A result word only follows a cycle in which a command was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy))
    else $error("result word without a command in progress");

  // An accepted command keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the unit busy");

  // The grid is never written while the unit is idle.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("grid written while idle");

  // Levels written back never exceed the saturation limit.
  a_level_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata <= LEVEL_MAX))
    else $error("level above limit written");

  // Each command gives a single one-cycle result strobe.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule
